@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ rtl/core/ipac_pkg.sv @@
// ----------------------------------------------------------------------------
// ipac_pkg
// Types, constants and helper functions of the address classifier.
// ----------------------------------------------------------------------------
package ipac_pkg;

	localparam int ADDR_W    = 64;
	localparam int CHUNK_W   = 16;
	localparam int NCHUNK    = 8;
	localparam int CHUNK_IDX_W = 3;
	localparam int CHUNK_TZ_W  = 4;
	localparam int TZ_W      = CHUNK_IDX_W + CHUNK_TZ_W;

	localparam int AF_W = 8;
	localparam int MF_W = 7;
	localparam int PL_W = 8;

	// Address flag bit positions.
	localparam int AF_WILDCARD  = 0;
	localparam int AF_BCAST     = 1;
	localparam int AF_ANY_BCAST = 2;
	localparam int AF_LOOPBACK  = 3;
	localparam int AF_LINKLOCAL = 4;
	localparam int AF_SITELOCAL = 5;
	localparam int AF_V4COMPAT  = 6;
	localparam int AF_V4MAPPED  = 7;

	// Multicast flag bit positions.
	localparam int MF_MCAST     = 0;
	localparam int MF_WELLKNOWN = 1;
	localparam int MF_NODELOCAL = 2;
	localparam int MF_LINKLOCAL = 3;
	localparam int MF_SITELOCAL = 4;
	localparam int MF_ORGLOCAL  = 5;
	localparam int MF_GLOBAL    = 6;

	localparam logic MODE_V4 = 1'b0;
	localparam logic MODE_V6 = 1'b1;

	localparam logic [PL_W-1:0] V4_BITS = 8'd32;
	localparam logic [PL_W-1:0] V6_BITS = 8'd128;

	// IPv4 classes.
	localparam logic [31:0] V4_ALL_ONES   = 32'hFFFFFFFF;
	localparam logic [7:0]  V4_BYTE_ONES  = 8'hFF;
	localparam logic [7:0]  V4_LOOP_NET   = 8'h7F;
	localparam logic [15:0] V4_LL_NET     = 16'hA9FE;
	localparam logic [7:0]  V4_PRIV_A     = 8'h0A;
	localparam logic [15:0] V4_PRIV_C     = 16'hC0A8;
	localparam logic [31:0] V4_PRIV_B_LO  = 32'hAC100000;
	localparam logic [31:0] V4_PRIV_B_HI  = 32'hAC1FFFFF;
	localparam logic [3:0]  V4_MC_NIB     = 4'hE;
	localparam logic [23:0] V4_MC_WK_NET  = 24'hE00000;
	localparam logic [7:0]  V4_MC_LL_NET  = 8'hE0;
	localparam logic [15:0] V4_MC_SITE    = 16'hEFFF;
	localparam logic [15:0] V4_MC_ORG     = 16'hEFC0;
	localparam logic [31:0] V4_MC_GLB_LO  = 32'hE0000100;
	localparam logic [31:0] V4_MC_GLB_HI  = 32'hEE000000;

	// IPv6 classes, tested on the first 16-bit word, and the v4-mapped tag.
	localparam logic [15:0] V6_PFX_MASK   = 16'hFFE0;
	localparam logic [15:0] V6_WK_MASK    = 16'hFFF0;
	localparam logic [15:0] V6_SCOPE_MASK = 16'hFFEF;
	localparam logic [15:0] V6_LL_PFX     = 16'hFE80;
	localparam logic [15:0] V6_SL_PFX     = 16'hFEC0;
	localparam logic [15:0] V6_MC_PFX     = 16'hFF00;
	localparam logic [15:0] V6_MC_NODE    = 16'hFF01;
	localparam logic [15:0] V6_MC_LINK    = 16'hFF02;
	localparam logic [15:0] V6_MC_SITE    = 16'hFF05;
	localparam logic [15:0] V6_MC_ORG     = 16'hFF08;
	localparam logic [15:0] V6_MC_GLB     = 16'hFF0F;
	localparam logic [31:0] V6_MAPPED_TAG = 32'h0000FFFF;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} stage_en_t;

	typedef struct packed {
		logic                                   mode;
		logic [AF_W-1:0]                        addr_flags;
		logic [MF_W-1:0]                        mc_flags;
		logic [NCHUNK-1:0]                      chunk_nz;
		logic [NCHUNK-1:0][CHUNK_TZ_W-1:0]      chunk_tz;
	} decode_t;

	// Trailing zeros of a 16-bit word by halving; a zero word is masked by chunk_nz.
	function automatic logic [CHUNK_TZ_W-1:0] tz16(input logic [CHUNK_W-1:0] v);
		logic [CHUNK_W-1:0]    x;
		logic [CHUNK_TZ_W-1:0] n;
		x = v;
		n = '0;
		if (x[7:0] == 8'h00) begin
			n[3] = 1'b1;
			x    = x >> 8;
		end
		if (x[3:0] == 4'h0) begin
			n[2] = 1'b1;
			x    = x >> 4;
		end
		if (x[1:0] == 2'b00) begin
			n[1] = 1'b1;
			x    = x >> 2;
		end
		if (!x[0]) begin
			n[0] = 1'b1;
		end
		return n;
	endfunction

	// Index of the lowest set bit of an 8-bit vector.
	function automatic logic [CHUNK_IDX_W-1:0] lsb8(input logic [NCHUNK-1:0] v);
		logic [NCHUNK-1:0]      x;
		logic [CHUNK_IDX_W-1:0] n;
		x = v;
		n = '0;
		if (x[3:0] == 4'h0) begin
			n[2] = 1'b1;
			x    = x >> 4;
		end
		if (x[1:0] == 2'b00) begin
			n[1] = 1'b1;
			x    = x >> 2;
		end
		if (!x[0]) begin
			n[0] = 1'b1;
		end
		return n;
	endfunction

endpackage

@@ rtl/core/ip_address_classifier_core.sv @@
// ----------------------------------------------------------------------------
// ip_address_classifier_core
// Classifies one IPv4 or IPv6 address per cycle into flags and a prefix length.
// ----------------------------------------------------------------------------
// Usage:
//   The item channel (item_valid/item_ready) carries the family selector mode
//   and the address in addr_hi/addr_lo. The result channel
//   (result_valid/result_ready) carries addr_flags, mc_flags and
//   prefix_length, one result per accepted item, in order.
//   An item is registered in the flag-compare stage, then the merge stage,
//   then the output stage, which drives the result ports. Throughput is
//   one item per cycle while result_ready is high. The three register
//   stages are the flag compares with per-word zero counts, the zero-count
//   merge, and the prefix subtraction that also forms the output register.
//   When the receiver holds result_ready low, the result stays on the ports
//   and the stages behind it keep filling; item_ready drops only once all
//   three stages hold an item.
//   Reset clears all stage valid bits; the block takes an item in the first
//   cycle after reset is released.
// ----------------------------------------------------------------------------
module ip_address_classifier_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        mode,
	input  logic [63:0] addr_hi,
	input  logic [63:0] addr_lo,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [7:0]  addr_flags,
	output logic [6:0]  mc_flags,
	output logic [7:0]  prefix_length
);

	logic                valid_s1, valid_s2, valid_s3;
	ipac_pkg::stage_en_t en;
	ipac_pkg::decode_t   dec_s1;

	// A stage loads when it is empty or its contents move on this cycle.
	assign en.s3 = !valid_s3 || result_ready;
	assign en.s2 = !valid_s2 || en.s3;
	assign en.s1 = !valid_s1 || en.s2;

	assign item_ready   = en.s1;
	assign result_valid = valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en.s1) begin
				valid_s1 <= item_valid;
			end
			if (en.s2) begin
				valid_s2 <= valid_s1;
			end
			if (en.s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	ipac_decode u_decode (
		.clk     (clk),
		.en      (en.s1),
		.mode    (mode),
		.addr_hi (addr_hi),
		.addr_lo (addr_lo),
		.dec_s1  (dec_s1)
	);

	ipac_prefix u_prefix (
		.clk              (clk),
		.en               (en),
		.dec_s1           (dec_s1),
		.addr_flags_s3    (addr_flags),
		.mc_flags_s3      (mc_flags),
		.prefix_length_s3 (prefix_length)
	);

endmodule

@@ rtl/core/ipac_decode.sv @@
// ----------------------------------------------------------------------------
// ipac_decode
// First stage: class and multicast flag compares, per-word zero counts.
// ----------------------------------------------------------------------------
module ipac_decode (
	input  logic               clk,
	input  logic               en,
	input  logic               mode,
	input  logic [63:0]        addr_hi,
	input  logic [63:0]        addr_lo,
	output ipac_pkg::decode_t  dec_s1
);

	logic [31:0]            a4;
	logic [15:0]            w0;
	logic [15:0]            sc;
	logic [127:0]           a128;
	logic [ipac_pkg::AF_W-1:0] af4, af6;
	logic [ipac_pkg::MF_W-1:0] mf4, mf6;
	ipac_pkg::decode_t      dec;

	assign a4 = addr_lo[31:0];
	assign w0 = addr_hi[63:48];
	assign sc = w0 & ipac_pkg::V6_SCOPE_MASK;

	always_comb begin
		af4 = '0;
		af4[ipac_pkg::AF_WILDCARD]  = (a4 == 32'h0);
		af4[ipac_pkg::AF_BCAST]     = (a4 == ipac_pkg::V4_ALL_ONES);
		af4[ipac_pkg::AF_ANY_BCAST] = (a4 == ipac_pkg::V4_ALL_ONES) ||
		                              (a4[7:0] == ipac_pkg::V4_BYTE_ONES);
		af4[ipac_pkg::AF_LOOPBACK]  = (a4[31:24] == ipac_pkg::V4_LOOP_NET);
		af4[ipac_pkg::AF_LINKLOCAL] = (a4[31:16] == ipac_pkg::V4_LL_NET);
		af4[ipac_pkg::AF_SITELOCAL] = (a4[31:24] == ipac_pkg::V4_PRIV_A) ||
		                              (a4[31:16] == ipac_pkg::V4_PRIV_C) ||
		                              ((a4 >= ipac_pkg::V4_PRIV_B_LO) &&
		                               (a4 <= ipac_pkg::V4_PRIV_B_HI));
		af4[ipac_pkg::AF_V4COMPAT]  = 1'b1;
		af4[ipac_pkg::AF_V4MAPPED]  = 1'b1;

		mf4 = '0;
		mf4[ipac_pkg::MF_MCAST]     = (a4[31:28] == ipac_pkg::V4_MC_NIB);
		mf4[ipac_pkg::MF_WELLKNOWN] = (a4[31:8] == ipac_pkg::V4_MC_WK_NET);
		mf4[ipac_pkg::MF_LINKLOCAL] = (a4[31:24] == ipac_pkg::V4_MC_LL_NET);
		mf4[ipac_pkg::MF_SITELOCAL] = (a4[31:16] == ipac_pkg::V4_MC_SITE);
		mf4[ipac_pkg::MF_ORGLOCAL]  = (a4[31:16] == ipac_pkg::V4_MC_ORG);
		mf4[ipac_pkg::MF_GLOBAL]    = (a4 >= ipac_pkg::V4_MC_GLB_LO) &&
		                              (a4 <= ipac_pkg::V4_MC_GLB_HI);

		af6 = '0;
		af6[ipac_pkg::AF_WILDCARD]  = (addr_hi == 64'h0) && (addr_lo == 64'h0);
		af6[ipac_pkg::AF_LOOPBACK]  = (addr_hi == 64'h0) && (addr_lo == 64'h1);
		af6[ipac_pkg::AF_LINKLOCAL] = ((w0 & ipac_pkg::V6_PFX_MASK) == ipac_pkg::V6_LL_PFX);
		af6[ipac_pkg::AF_SITELOCAL] = ((w0 & ipac_pkg::V6_PFX_MASK) == ipac_pkg::V6_SL_PFX);
		af6[ipac_pkg::AF_V4COMPAT]  = (addr_hi == 64'h0) && (addr_lo[63:32] == 32'h0);
		af6[ipac_pkg::AF_V4MAPPED]  = (addr_hi == 64'h0) &&
		                              (addr_lo[63:32] == ipac_pkg::V6_MAPPED_TAG);

		mf6 = '0;
		mf6[ipac_pkg::MF_MCAST]     = ((w0 & ipac_pkg::V6_PFX_MASK) == ipac_pkg::V6_MC_PFX);
		mf6[ipac_pkg::MF_WELLKNOWN] = ((w0 & ipac_pkg::V6_WK_MASK) == ipac_pkg::V6_MC_PFX);
		mf6[ipac_pkg::MF_NODELOCAL] = (sc == ipac_pkg::V6_MC_NODE);
		mf6[ipac_pkg::MF_LINKLOCAL] = (sc == ipac_pkg::V6_MC_LINK);
		mf6[ipac_pkg::MF_SITELOCAL] = (sc == ipac_pkg::V6_MC_SITE);
		mf6[ipac_pkg::MF_ORGLOCAL]  = (sc == ipac_pkg::V6_MC_ORG);
		mf6[ipac_pkg::MF_GLOBAL]    = (sc == ipac_pkg::V6_MC_GLB);
	end

	// An IPv4 address is counted as a 128-bit value with zero upper bits.
	assign a128 = (mode == ipac_pkg::MODE_V6) ? {addr_hi, addr_lo} : {96'h0, a4};

	always_comb begin
		dec.mode       = mode;
		dec.addr_flags = (mode == ipac_pkg::MODE_V6) ? af6 : af4;
		dec.mc_flags   = (mode == ipac_pkg::MODE_V6) ? mf6 : mf4;
		for (int i = 0; i < ipac_pkg::NCHUNK; i++) begin
			dec.chunk_nz[i] = |a128[i*ipac_pkg::CHUNK_W +: ipac_pkg::CHUNK_W];
			dec.chunk_tz[i] = ipac_pkg::tz16(a128[i*ipac_pkg::CHUNK_W +: ipac_pkg::CHUNK_W]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dec_s1 <= dec;
		end
	end

endmodule

@@ rtl/core/ipac_prefix.sv @@
// ----------------------------------------------------------------------------
// ipac_prefix
// Second and third stages: trailing-zero merge and prefix length.
// ----------------------------------------------------------------------------
module ipac_prefix (
	input  logic                       clk,
	input  ipac_pkg::stage_en_t        en,
	input  ipac_pkg::decode_t          dec_s1,
	output logic [ipac_pkg::AF_W-1:0]  addr_flags_s3,
	output logic [ipac_pkg::MF_W-1:0]  mc_flags_s3,
	output logic [ipac_pkg::PL_W-1:0]  prefix_length_s3
);

	logic [ipac_pkg::CHUNK_IDX_W-1:0] idx;
	logic                             mode_s2;
	logic                             zero_s2;
	logic [ipac_pkg::TZ_W-1:0]        tz_s2;
	logic [ipac_pkg::AF_W-1:0]        addr_flags_s2;
	logic [ipac_pkg::MF_W-1:0]        mc_flags_s2;
	logic [ipac_pkg::PL_W-1:0]        width;

	assign idx = ipac_pkg::lsb8(dec_s1.chunk_nz);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			mode_s2       <= dec_s1.mode;
			zero_s2       <= ~|dec_s1.chunk_nz;
			tz_s2         <= {idx, dec_s1.chunk_tz[idx]};
			addr_flags_s2 <= dec_s1.addr_flags;
			mc_flags_s2   <= dec_s1.mc_flags;
		end
	end

	assign width = (mode_s2 == ipac_pkg::MODE_V6) ? ipac_pkg::V6_BITS : ipac_pkg::V4_BITS;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			addr_flags_s3    <= addr_flags_s2;
			mc_flags_s3      <= mc_flags_s2;
			prefix_length_s3 <= zero_s2 ? '0 : (width - {1'b0, tz_s2});
		end
	end

endmodule

@@ rtl/core/ipac_checker.sv @@
// ----------------------------------------------------------------------------
// ipac_checker
// Port-level checks on the result channel of the address classifier.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipac_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       result_valid,
	input  logic       result_ready,
	input  logic [7:0] addr_flags,
	input  logic [6:0] mc_flags,
	input  logic [7:0] prefix_length
);

	// A stalled result transfer keeps its valid and its payload.
	`ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(addr_flags) && $stable(mc_flags) && $stable(prefix_length))

	// Only the all-zero address has a zero prefix length, and it is the wildcard.
	`ASSERT_IMPLIES(a_wildcard_prefix, clk, arst_n, result_valid, addr_flags[ipac_pkg::AF_WILDCARD] == (prefix_length == 8'd0))

	// The broadcast address is IPv4 all-ones.
	`ASSERT_IMPLIES(a_bcast_prefix, clk, arst_n, result_valid && addr_flags[ipac_pkg::AF_BCAST], addr_flags[ipac_pkg::AF_ANY_BCAST] && (prefix_length == 8'd32))

	// A multicast address is never zero, and well-known implies multicast.
	`ASSERT_IMPLIES(a_mcast_nonzero, clk, arst_n, result_valid && mc_flags[ipac_pkg::MF_WELLKNOWN], mc_flags[ipac_pkg::MF_MCAST] && (prefix_length != 8'd0))

endmodule

bind ip_address_classifier_core ipac_checker u_ipac_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.result_valid  (result_valid),
	.result_ready  (result_ready),
	.addr_flags    (addr_flags),
	.mc_flags      (mc_flags),
	.prefix_length (prefix_length)
);
